/* hw/rtl/ffha_pkg.sv */
package ffha_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int FRAME_BYTES_DEF = 4096;
    localparam int ALIGN_BYTES_DEF = 16;

    localparam int HDR_BYTES = 16;
    localparam int ADDR_W    = 48;
    localparam int REQ_W     = 17;
    localparam int LIMIT_W   = 5;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'd1;

    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 5'd16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM    = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACHK,
        S_AEVAL,
        S_GROW,
        S_SPLIT,
        S_HEAD,
        S_FCHK,
        S_FSZ,
        S_FNXT,
        S_FEVAL,
        S_FWR,
        S_OUT
    } t_state;

endpackage

/* hw/rtl/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator over an implicit free list of 16-byte headers.
// Input channel (i_valid/o_ready): i_op selects allocate or free, with
// i_request_size for allocate and i_free_address for free. Output channel
// (o_valid/i_ready): o_block_address and o_status, one item per request.
// Configuration: i_cfg_we writes i_cfg_data to heap_base (index 0) or
// frame_limit (index 1); write only while the unit is idle.
// After accept, an allocate walks the block headers, reading and comparing
// each; a fitting block is then split and its header written. Growing ends
// the walk, runs the grow check, splits and writes the header, and an
// out-of-memory ends at the grow check. A free checks the address, reads
// the block size, merges each following free neighbor, checks a used block
// that ends the merge and writes the header; a zero-size or rejected
// request skips to hand-off. Every request ends with a hand-off to the
// output register. The header memory read port paces these steps; one
// request is in flight at a time; o_ready is high only between requests.
// Reset clears the heap top (nothing mapped), sets heap_base to 0 and
// frame_limit to 16; the header memory is not cleared and needs no sweep.
// When the receiver stalls, the result stays in the output register and
// the next request may be accepted; that request then waits at hand-off
// until the output register is free.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES  = ffha_pkg::HEAP_BYTES_DEF,
    parameter int FRAME_BYTES = ffha_pkg::FRAME_BYTES_DEF,
    parameter int ALIGN_BYTES = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [ffha_pkg::REQ_W-1:0]      i_request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]     i_free_address,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ffha_pkg::ADDR_W-1:0]     o_block_address,
    output logic [ffha_pkg::STAT_W-1:0]     o_status,
    input  logic                            i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffha_pkg::ADDR_W-1:0]     i_cfg_data
);

    localparam int SLOTS = HEAP_BYTES / ffha_pkg::HDR_BYTES;
    localparam int AW    = $clog2(SLOTS);
    localparam int SW    = $clog2(HEAP_BYTES + 1);
    localparam int BW    = (SW > ffha_pkg::REQ_W ? SW : ffha_pkg::REQ_W) + 2;
    localparam int HW    = SW + 1;
    localparam int FS    = $clog2(FRAME_BYTES);
    localparam int AS    = $clog2(ALIGN_BYTES);
    localparam int AWD   = ffha_pkg::ADDR_W;

    localparam logic [BW-1:0]  HDR_B   = BW'(ffha_pkg::HDR_BYTES);
    localparam logic [BW-1:0]  SPLIT_B = BW'(ffha_pkg::HDR_BYTES + ALIGN_BYTES);
    localparam logic [BW-1:0]  ALIGN_M = BW'(ALIGN_BYTES - 1);
    localparam logic [BW-1:0]  FRAME_M = BW'(FRAME_BYTES - 1);
    localparam logic [BW:0]    HEAP_B  = (BW + 1)'(HEAP_BYTES);

    ffha_pkg::t_state r_state, n_state;

    logic [BW-1:0]   r_size, n_size;
    logic [BW-1:0]   r_off, n_off;
    logic [BW-1:0]   r_bsize, n_bsize;
    logic [BW-1:0]   r_next, n_next;
    logic [SW-1:0]   r_top, n_top;
    logic [AWD-1:0]  r_faddr, n_faddr;
    logic [AWD-1:0]  r_base;
    logic [ffha_pkg::LIMIT_W-1:0] r_flim;
    logic [AWD-1:0]  r_res_addr, n_res_addr;
    logic [ffha_pkg::STAT_W-1:0] r_res_stat, n_res_stat;
    logic            r_ovalid, n_ovalid;
    logic [AWD-1:0]  r_oaddr, n_oaddr;
    logic [ffha_pkg::STAT_W-1:0] r_ostat, n_ostat;

    logic [HW-1:0]   mem [SLOTS];
    logic [HW-1:0]   r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [HW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic            rd_free;
    logic [BW-1:0]   rd_size;
    logic [BW-1:0]   rest;
    logic [BW-1:0]   split_off;
    logic [BW-1:0]   frames;
    logic [BW:0]     grow;
    logic [BW:0]     mapped;
    logic [AWD-1:0]  foff;
    logic [BW-1:0]   top_b;

    assign rd_free   = r_rdata[HW-1];
    assign rd_size   = BW'(r_rdata[SW-1:0]);
    assign top_b     = BW'(r_top);
    assign rest      = r_bsize - r_size;
    assign split_off = r_off + HDR_B + r_size;
    assign frames    = (r_size + HDR_B + FRAME_M) >> FS;
    assign grow      = (BW + 1)'(frames) << FS;
    assign mapped    = (BW + 1)'(top_b >> FS) + (BW + 1)'(frames);
    assign foff      = r_faddr - r_base - AWD'(ffha_pkg::HDR_BYTES);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffha_pkg::S_IDLE;
            r_top    <= '0;
            r_ovalid <= 1'b0;
            r_base   <= '0;
            r_flim   <= ffha_pkg::FRAME_LIMIT_RST;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
            if (i_cfg_we && i_cfg_idx == ffha_pkg::CFG_HEAP_BASE) begin
                r_base <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == ffha_pkg::CFG_FRAME_LIMIT) begin
                r_flim <= i_cfg_data[ffha_pkg::LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_off      <= n_off;
        r_bsize    <= n_bsize;
        r_next     <= n_next;
        r_faddr    <= n_faddr;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
        r_oaddr    <= n_oaddr;
        r_ostat    <= n_ostat;
    end

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_off      = r_off;
        n_bsize    = r_bsize;
        n_next     = r_next;
        n_top      = r_top;
        n_faddr    = r_faddr;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        n_ovalid   = r_ovalid && !i_ready;
        n_oaddr    = r_oaddr;
        n_ostat    = r_ostat;
        mem_we     = 1'b0;
        mem_waddr  = r_off[AW+3:4];
        mem_wdata  = '0;
        mem_raddr  = r_off[AW+3:4];
        o_ready    = 1'b0;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                n_res_addr = '0;
                n_res_stat = ffha_pkg::ST_DONE;
                n_size     = (BW'(i_request_size) + ALIGN_M) >> AS << AS;
                n_faddr    = i_free_address;
                n_off      = '0;
                if (i_valid) begin
                    if (i_op == ffha_pkg::OP_ALLOC) begin
                        if (i_request_size == '0) begin
                            n_res_stat = ffha_pkg::ST_IGNORE;
                            n_state    = ffha_pkg::S_OUT;
                        end else begin
                            n_state = ffha_pkg::S_ACHK;
                        end
                    end else begin
                        n_state = ffha_pkg::S_FCHK;
                    end
                end
            end
            ffha_pkg::S_ACHK: begin
                if (r_off < top_b) begin
                    n_state = ffha_pkg::S_AEVAL;
                end else begin
                    n_state = ffha_pkg::S_GROW;
                end
            end
            ffha_pkg::S_AEVAL: begin
                if (rd_free && rd_size >= r_size) begin
                    n_bsize = rd_size;
                    n_state = ffha_pkg::S_SPLIT;
                end else begin
                    n_off   = r_off + HDR_B + rd_size;
                    n_state = ffha_pkg::S_ACHK;
                end
            end
            ffha_pkg::S_GROW: begin
                if (mapped > (BW + 1)'(r_flim) ||
                    (BW + 1)'(top_b) + grow > HEAP_B) begin
                    n_res_stat = ffha_pkg::ST_OOM;
                    n_state    = ffha_pkg::S_OUT;
                end else begin
                    n_off   = top_b;
                    n_top   = SW'((BW + 1)'(top_b) + grow);
                    n_bsize = BW'(grow) - HDR_B;
                    n_state = ffha_pkg::S_SPLIT;
                end
            end
            ffha_pkg::S_SPLIT: begin
                if (rest >= SPLIT_B) begin
                    mem_we    = 1'b1;
                    mem_waddr = split_off[AW+3:4];
                    mem_wdata = {1'b1, SW'(rest - HDR_B)};
                    n_bsize   = r_size;
                end
                n_state = ffha_pkg::S_HEAD;
            end
            ffha_pkg::S_HEAD: begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b0, SW'(r_bsize)};
                n_res_addr = r_base + AWD'(r_off) + AWD'(ffha_pkg::HDR_BYTES);
                n_state    = ffha_pkg::S_OUT;
            end
            ffha_pkg::S_FCHK: begin
                n_off     = BW'(foff);
                mem_raddr = foff[AW+3:4];
                if (r_faddr == '0 || foff[3:0] != 4'd0 || foff >= AWD'(r_top)) begin
                    n_res_stat = ffha_pkg::ST_IGNORE;
                    n_state    = ffha_pkg::S_OUT;
                end else begin
                    n_state = ffha_pkg::S_FSZ;
                end
            end
            ffha_pkg::S_FSZ: begin
                n_bsize = rd_size;
                n_next  = r_off + HDR_B + rd_size;
                n_state = ffha_pkg::S_FNXT;
            end
            ffha_pkg::S_FNXT: begin
                mem_raddr = r_next[AW+3:4];
                if (r_next < top_b) begin
                    n_state = ffha_pkg::S_FEVAL;
                end else begin
                    n_state = ffha_pkg::S_FWR;
                end
            end
            ffha_pkg::S_FEVAL: begin
                if (rd_free) begin
                    n_bsize = r_bsize + HDR_B + rd_size;
                    n_next  = r_off + HDR_B + r_bsize + HDR_B + rd_size;
                    n_state = ffha_pkg::S_FNXT;
                end else begin
                    n_state = ffha_pkg::S_FWR;
                end
            end
            ffha_pkg::S_FWR: begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, SW'(r_bsize)};
                n_state   = ffha_pkg::S_OUT;
            end
            ffha_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_res_addr;
                    n_ostat  = r_res_stat;
                    n_state  = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_block_address = r_oaddr;
    assign o_status        = r_ostat;

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ffha_pkg::S_IDLE |-> !mem_we)
        else $error("header write while idle");
    a_top_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top[FS-1:0] == '0)
        else $error("heap top not frame aligned");
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (BW + 1)'(r_top) <= HEAP_B)
        else $error("heap top beyond heap");
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ffha_pkg::ST_DONE || o_status == ffha_pkg::ST_OOM ||
                     o_status == ffha_pkg::ST_IGNORE))
        else $error("bad status code");
    a_addr_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ffha_pkg::ST_DONE |-> o_block_address == '0)
        else $error("address on failed request");
`endif

endmodule
